@@ hdl/g6pc_pkg.sv @@
// Shared types and constants for the graph6 check unit for cycles of power-of-two length.
package g6pc_pkg;

   localparam int ROW_BITS       = 64;
   localparam int VTX_BITS       = 6;
   localparam int MAX_VERTICES   = 62;
   localparam int CHAR_BIAS      = 63;
   localparam int BITS_PER_CHAR  = 6;
   localparam int C4_LEN         = 4;
   localparam int FIRST_LONG_LEN = 8;
   localparam int LEN_STEPS      = 3;

   typedef logic [ROW_BITS-1:0] row_type;
   typedef logic [VTX_BITS-1:0] vtx_type;
   typedef logic [1:0]          verdict_type;

   localparam verdict_type VERDICT_NONE = 2'd0;
   localparam verdict_type VERDICT_C4   = 2'd1;
   localparam verdict_type VERDICT_LONG = 2'd2;
   localparam verdict_type VERDICT_BAD  = 2'd3;

   typedef struct packed {
      vtx_type rd_addr;
      logic    wr_en;
      vtx_type wr_addr;
      row_type wr_data;
      logic    clear;
   } adj_req_type;

   typedef struct packed {
      row_type row;
      vtx_type vertex;
      vtx_type cursor;
   } stack_entry_type;

   typedef struct packed {
      logic            wr_en;
      vtx_type         wr_addr;
      stack_entry_type wr_data;
      vtx_type         rd_addr;
   } stack_req_type;

endpackage

@@ hdl/graph6_power_of_two_cycle_check_unit.sv @@
// Top level of the graph6 check unit for cycles of power-of-two length.
// A header beat is absorbed in ST_IDLE. A data beat then walks its bits in ST_BIT; each one bit
// also passes ST_WRA and ST_WRB (read-modify-write of both rows in the adjacency RAM).
// After the last beat, the C4 scan compares one row pair per read; the depth-first search
// reads an adjacency row on each push and a stack entry on each pop, so its run time depends
// on the graph. One line is processed at a time.
// Reset is synchronous; row valid bits clear the adjacency store per graph with no sweep.
module graph6_power_of_two_cycle_check_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_char_byte,
   input  logic        req_last,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_verdict,
   output logic [5:0]  rsp_cycle_length,
   output logic [5:0]  rsp_vertex_count
);
   import g6pc_pkg::*;

   typedef enum logic [12:0] {
      ST_IDLE     = 13'b0000000000001,
      ST_BIT      = 13'b0000000000010,
      ST_WRA      = 13'b0000000000100,
      ST_WRB      = 13'b0000000001000,
      ST_C4_START = 13'b0000000010000,
      ST_C4_ROW   = 13'b0000000100000,
      ST_C4_SCAN  = 13'b0000001000000,
      ST_LEN      = 13'b0000010000000,
      ST_ROOT     = 13'b0000100000000,
      ST_ROWWAIT  = 13'b0001000000000,
      ST_STEP     = 13'b0010000000000,
      ST_POP      = 13'b0100000000000,
      ST_DONE     = 13'b1000000000000
   } state_type;

   state_type       state_ff, state_in;
   logic            header_seen_ff, header_seen_in;
   logic            bad_ff, bad_in;
   logic            last_ff, last_in;
   vtx_type         n_ff, n_in;
   vtx_type         pair_row_ff, pair_row_in;
   vtx_type         pair_col_ff, pair_col_in;
   logic [5:0]      shreg_ff, shreg_in;
   logic [2:0]      bit_cnt_ff, bit_cnt_in;
   vtx_type         c4_i_ff, c4_i_in;
   vtx_type         c4_j_ff, c4_j_in;
   row_type         row_i_ff, row_i_in;
   logic [1:0]      len_idx_ff, len_idx_in;
   vtx_type         root_ff, root_in;
   vtx_type         depth_ff, depth_in;
   vtx_type         top_u_ff, top_u_in;
   vtx_type         top_cur_ff, top_cur_in;
   row_type         top_row_ff, top_row_in;
   row_type         visited_ff, visited_in;
   verdict_type     res_verdict_ff, res_verdict_in;
   vtx_type         res_len_ff, res_len_in;
   logic            rsp_valid_ff, rsp_valid_in;
   verdict_type     rsp_verdict_ff, rsp_verdict_in;
   vtx_type         rsp_len_ff, rsp_len_in;
   vtx_type         rsp_count_ff, rsp_count_in;

   adj_req_type     adj_req;
   row_type         adj_rd_data;
   stack_req_type   stk_req;
   stack_entry_type stk_rd_data;

   logic [6:0]      len_w;
   row_type         pair_and;
   logic            pair_hit;
   row_type         cand;
   logic            cand_any;
   vtx_type         cand_w;
   vtx_type         k_idx;
   logic [7:0]      data_val;
   logic            hdr_bad;

   g6pc_adj_store u_adj (
      .clock   (clock),
      .reset   (reset),
      .req     (adj_req),
      .rd_data (adj_rd_data)
   );

   g6pc_stack u_stack (
      .clock   (clock),
      .req     (stk_req),
      .rd_data (stk_rd_data)
   );

   // Current cycle length under test: 8, 16, 32.
   assign len_w    = 7'(FIRST_LONG_LEN) << len_idx_ff;
   // Two or more common neighbors: clear the lowest one and test what is left.
   assign pair_and = row_i_ff & adj_rd_data;
   assign pair_hit = (pair_and & (pair_and - row_type'(1))) != '0;
   assign k_idx    = depth_ff - vtx_type'(1);
   assign data_val = req_char_byte - 8'(CHAR_BIAS);
   assign hdr_bad  = (req_char_byte < 8'(CHAR_BIAS)) ||
                     (req_char_byte > 8'(CHAR_BIAS + MAX_VERTICES));

   // Unvisited neighbors at or past the cursor and below the vertex count.
   assign cand = top_row_ff & ~visited_ff & (~row_type'(0) << top_cur_ff) &
                 ((row_type'(1) << n_ff) - row_type'(1));
   assign cand_any = cand != '0;

   // Lowest set candidate bit.
   always_comb begin
      cand_w = '0;
      for (int i = ROW_BITS - 1; i >= 0; i--) begin
         if (cand[i]) begin
            cand_w = vtx_type'(i);
         end
      end
   end

   always_comb begin
      state_in       = state_ff;
      header_seen_in = header_seen_ff;
      bad_in         = bad_ff;
      last_in        = last_ff;
      n_in           = n_ff;
      pair_row_in    = pair_row_ff;
      pair_col_in    = pair_col_ff;
      shreg_in       = shreg_ff;
      bit_cnt_in     = bit_cnt_ff;
      c4_i_in        = c4_i_ff;
      c4_j_in        = c4_j_ff;
      row_i_in       = row_i_ff;
      len_idx_in     = len_idx_ff;
      root_in        = root_ff;
      depth_in       = depth_ff;
      top_u_in       = top_u_ff;
      top_cur_in     = top_cur_ff;
      top_row_in     = top_row_ff;
      visited_in     = visited_ff;
      res_verdict_in = res_verdict_ff;
      res_len_in     = res_len_ff;
      rsp_verdict_in = rsp_verdict_ff;
      rsp_len_in     = rsp_len_ff;
      rsp_count_in   = rsp_count_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;

      adj_req         = '0;
      adj_req.rd_addr = pair_row_ff;
      stk_req         = '0;
      stk_req.rd_addr = k_idx;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               last_in = req_last;
               if (!header_seen_ff) begin
                  // Header beat: start a new graph.
                  header_seen_in = 1'b1;
                  adj_req.clear  = 1'b1;
                  pair_row_in    = '0;
                  pair_col_in    = vtx_type'(1);
                  bad_in         = hdr_bad;
                  n_in           = hdr_bad ? vtx_type'(0) : data_val[VTX_BITS-1:0];
                  if (req_last) begin
                     if (hdr_bad) begin
                        res_verdict_in = VERDICT_BAD;
                        res_len_in     = '0;
                        state_in       = ST_DONE;
                     end else begin
                        state_in = ST_C4_START;
                     end
                  end
               end else if (bad_ff) begin
                  // Drop data after a bad header.
                  if (req_last) begin
                     res_verdict_in = VERDICT_BAD;
                     res_len_in     = '0;
                     state_in       = ST_DONE;
                  end
               end else begin
                  shreg_in   = data_val[5:0];
                  bit_cnt_in = 3'(BITS_PER_CHAR);
                  state_in   = ST_BIT;
               end
            end
         end

         ST_BIT: begin
            if (bit_cnt_ff == '0 || pair_col_ff >= n_ff) begin
               state_in = last_ff ? ST_C4_START : ST_IDLE;
            end else if (shreg_ff[5]) begin
               adj_req.rd_addr = pair_row_ff;
               state_in        = ST_WRA;
            end else begin
               shreg_in   = {shreg_ff[4:0], 1'b0};
               bit_cnt_in = bit_cnt_ff - 3'd1;
               if (pair_row_ff + vtx_type'(1) == pair_col_ff) begin
                  pair_row_in = '0;
                  pair_col_in = pair_col_ff + vtx_type'(1);
               end else begin
                  pair_row_in = pair_row_ff + vtx_type'(1);
               end
            end
         end

         ST_WRA: begin
            adj_req.wr_en   = 1'b1;
            adj_req.wr_addr = pair_row_ff;
            adj_req.wr_data = adj_rd_data | (row_type'(1) << pair_col_ff);
            adj_req.rd_addr = pair_col_ff;
            state_in        = ST_WRB;
         end

         ST_WRB: begin
            adj_req.wr_en   = 1'b1;
            adj_req.wr_addr = pair_col_ff;
            adj_req.wr_data = adj_rd_data | (row_type'(1) << pair_row_ff);
            shreg_in        = {shreg_ff[4:0], 1'b0};
            bit_cnt_in      = bit_cnt_ff - 3'd1;
            if (pair_row_ff + vtx_type'(1) == pair_col_ff) begin
               pair_row_in = '0;
               pair_col_in = pair_col_ff + vtx_type'(1);
            end else begin
               pair_row_in = pair_row_ff + vtx_type'(1);
            end
            state_in = ST_BIT;
         end

         ST_C4_START: begin
            if (n_ff < vtx_type'(2)) begin
               len_idx_in = '0;
               state_in   = ST_LEN;
            end else begin
               c4_i_in         = '0;
               adj_req.rd_addr = '0;
               state_in        = ST_C4_ROW;
            end
         end

         ST_C4_ROW: begin
            row_i_in        = adj_rd_data;
            c4_j_in         = c4_i_ff + vtx_type'(1);
            adj_req.rd_addr = c4_i_ff + vtx_type'(1);
            state_in        = ST_C4_SCAN;
         end

         ST_C4_SCAN: begin
            // Row c4_j arrives now; stream the next row behind it.
            if (pair_hit) begin
               res_verdict_in = VERDICT_C4;
               res_len_in     = vtx_type'(C4_LEN);
               state_in       = ST_DONE;
            end else if ({1'b0, c4_j_ff} + 7'd1 < {1'b0, n_ff}) begin
               c4_j_in         = c4_j_ff + vtx_type'(1);
               adj_req.rd_addr = c4_j_ff + vtx_type'(1);
            end else if ({1'b0, c4_i_ff} + 7'd2 < {1'b0, n_ff}) begin
               c4_i_in         = c4_i_ff + vtx_type'(1);
               adj_req.rd_addr = c4_i_ff + vtx_type'(1);
               state_in        = ST_C4_ROW;
            end else begin
               len_idx_in = '0;
               state_in   = ST_LEN;
            end
         end

         ST_LEN: begin
            if (len_idx_ff == 2'(LEN_STEPS) || len_w > {1'b0, n_ff}) begin
               res_verdict_in = VERDICT_NONE;
               res_len_in     = '0;
               state_in       = ST_DONE;
            end else begin
               root_in  = '0;
               state_in = ST_ROOT;
            end
         end

         ST_ROOT: begin
            if (root_ff >= n_ff) begin
               len_idx_in = len_idx_ff + 2'd1;
               state_in   = ST_LEN;
            end else begin
               adj_req.rd_addr = root_ff;
               visited_in      = row_type'(1) << root_ff;
               depth_in        = vtx_type'(1);
               top_u_in        = root_ff;
               top_cur_in      = root_ff;
               state_in        = ST_ROWWAIT;
            end
         end

         ST_ROWWAIT: begin
            top_row_in = adj_rd_data;
            state_in   = ST_STEP;
         end

         ST_STEP: begin
            if ({1'b0, depth_ff} == len_w && top_row_ff[root_ff]) begin
               res_verdict_in = VERDICT_LONG;
               res_len_in     = len_w[VTX_BITS-1:0];
               state_in       = ST_DONE;
            end else if ({1'b0, depth_ff} != len_w && cand_any) begin
               // Push: save the top with its advanced cursor, descend to the neighbor.
               stk_req.wr_en          = 1'b1;
               stk_req.wr_addr        = k_idx;
               stk_req.wr_data.row    = top_row_ff;
               stk_req.wr_data.vertex = top_u_ff;
               stk_req.wr_data.cursor = cand_w + vtx_type'(1);
               visited_in             = visited_ff | (row_type'(1) << cand_w);
               top_u_in               = cand_w;
               top_cur_in             = root_ff;
               depth_in               = depth_ff + vtx_type'(1);
               adj_req.rd_addr        = cand_w;
               state_in               = ST_ROWWAIT;
            end else if (k_idx == '0) begin
               root_in  = root_ff + vtx_type'(1);
               state_in = ST_ROOT;
            end else begin
               // Pop: release the vertex and restore the level below.
               visited_in      = visited_ff & ~(row_type'(1) << top_u_ff);
               depth_in        = k_idx;
               stk_req.rd_addr = k_idx - vtx_type'(1);
               state_in        = ST_POP;
            end
         end

         ST_POP: begin
            top_row_in = stk_rd_data.row;
            top_u_in   = stk_rd_data.vertex;
            top_cur_in = stk_rd_data.cursor;
            state_in   = ST_STEP;
         end

         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in   = 1'b1;
               rsp_verdict_in = res_verdict_ff;
               rsp_len_in     = res_len_ff;
               rsp_count_in   = n_ff;
               header_seen_in = 1'b0;
               bad_in         = 1'b0;
               n_in           = '0;
               state_in       = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         header_seen_ff <= 1'b0;
         bad_ff         <= 1'b0;
         n_ff           <= '0;
         pair_row_ff    <= '0;
         pair_col_ff    <= vtx_type'(1);
         visited_ff     <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         header_seen_ff <= header_seen_in;
         bad_ff         <= bad_in;
         n_ff           <= n_in;
         pair_row_ff    <= pair_row_in;
         pair_col_ff    <= pair_col_in;
         visited_ff     <= visited_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // Payload and scratch registers need no reset.
   always_ff @(posedge clock) begin
      last_ff        <= last_in;
      shreg_ff       <= shreg_in;
      bit_cnt_ff     <= bit_cnt_in;
      c4_i_ff        <= c4_i_in;
      c4_j_ff        <= c4_j_in;
      row_i_ff       <= row_i_in;
      len_idx_ff     <= len_idx_in;
      root_ff        <= root_in;
      depth_ff       <= depth_in;
      top_u_ff       <= top_u_in;
      top_cur_ff     <= top_cur_in;
      top_row_ff     <= top_row_in;
      res_verdict_ff <= res_verdict_in;
      res_len_ff     <= res_len_in;
      rsp_verdict_ff <= rsp_verdict_in;
      rsp_len_ff     <= rsp_len_in;
      rsp_count_ff   <= rsp_count_in;
   end

   assign req_ready        = state_ff == ST_IDLE;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_verdict      = rsp_verdict_ff;
   assign rsp_cycle_length = rsp_len_ff;
   assign rsp_vertex_count = rsp_count_ff;

   // The triangle walk keeps the row strictly below the column.
   a_pair_order: assert property (@(posedge clock) disable iff (reset)
      pair_row_ff < pair_col_ff)
      else $error("pair row not below pair column");

   // Every vertex on the current path is marked visited, and nothing else.
   a_visited_depth: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_STEP) |-> ($countones(visited_ff) == int'(depth_ff)))
      else $error("visited mask does not match search depth");

   // The path never grows past the cycle length under test.
   a_depth_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_STEP) |-> ({1'b0, depth_ff} <= len_w))
      else $error("search depth beyond cycle length");

   // The root stays on the path while its search runs.
   a_root_visited: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_STEP || state_ff == ST_POP) |-> visited_ff[root_ff])
      else $error("search root not marked visited");

endmodule

@@ hdl/g6pc_adj_store.sv @@
// Adjacency row memory with per-row valid bits; invalid rows read as zero.
module g6pc_adj_store (
   input  logic                  clock,
   input  logic                  reset,
   input  g6pc_pkg::adj_req_type req,
   output g6pc_pkg::row_type     rd_data
);
   import g6pc_pkg::*;

   row_type                mem [ROW_BITS];
   logic [ROW_BITS-1:0]    valid_ff;
   row_type                rd_q_ff;
   logic                   rd_valid_ff;

   always_ff @(posedge clock) begin
      if (req.wr_en) begin
         mem[req.wr_addr] <= req.wr_data;
      end
      rd_q_ff <= mem[req.rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         rd_valid_ff <= valid_ff[req.rd_addr];
         if (req.clear) begin
            valid_ff <= '0;
         end else if (req.wr_en) begin
            valid_ff[req.wr_addr] <= 1'b1;
         end
      end
   end

   assign rd_data = rd_valid_ff ? rd_q_ff : '0;

endmodule

@@ hdl/g6pc_stack.sv @@
// Search stack memory: saved path vertex, neighbor cursor and row per level.
module g6pc_stack (
   input  logic                      clock,
   input  g6pc_pkg::stack_req_type   req,
   output g6pc_pkg::stack_entry_type rd_data
);
   import g6pc_pkg::*;

   stack_entry_type mem [ROW_BITS];
   stack_entry_type rd_q_ff;

   always_ff @(posedge clock) begin
      if (req.wr_en) begin
         mem[req.wr_addr] <= req.wr_data;
      end
      rd_q_ff <= mem[req.rd_addr];
   end

   assign rd_data = rd_q_ff;

endmodule

@@ dv/testbench.sv @@
// Self-checking testbench for the graph6 check unit for cycles of power-of-two length.
`timescale 1ns / 1ps

module testbench;
   import g6pc_pkg::*;

   localparam int IDLE_PCT     = 27;
   localparam int SETTLE_WAIT  = 40;      // covers the slowest data beat with margin
   localparam int STALL_LIMIT  = 500000;  // cycles with no beat on either channel
   localparam int RANDOM_BEATS = 580;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [7:0]  req_char_byte;
   logic        req_last;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [1:0]  rsp_verdict;
   logic [5:0]  rsp_cycle_length;
   logic [5:0]  rsp_vertex_count;

   typedef struct {
      verdict_type verdict;
      vtx_type     cycle_length;
      vtx_type     vertex_count;
   } verdict_beat_type;

   verdict_beat_type verdict_q[$];

   // Shadow of the line decoder and adjacency store
   row_type     shadow_rows[ROW_BITS];
   int unsigned shadow_size;
   int unsigned shadow_row;
   int unsigned shadow_col;
   bit          shadow_hdr_seen;
   bit          shadow_hdr_bad;

   // Graph under construction for the next line
   row_type     graph_rows[ROW_BITS];

   int  error_count = 0;
   int  beats_sent  = 0;
   bit  idle_on     = 1'b1;
   int  stall_count = 0;

   graph6_power_of_two_cycle_check_unit uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_char_byte    (req_char_byte),
      .req_last         (req_last),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_verdict      (rsp_verdict),
      .rsp_cycle_length (rsp_cycle_length),
      .rsp_vertex_count (rsp_vertex_count)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // Predictor
   // ---------------------------------------------------------------------
   function automatic void clear_shadow();
      for (int i = 0; i < ROW_BITS; i++) shadow_rows[i] = '0;
      shadow_size     = 0;
      shadow_row      = 0;
      shadow_col      = 1;
      shadow_hdr_seen = 1'b0;
      shadow_hdr_bad  = 1'b0;
   endfunction

   function automatic void absorb_data(logic [7:0] byte_in);
      logic [7:0] val;
      val = byte_in - 8'(CHAR_BIAS);
      for (int b = BITS_PER_CHAR - 1; b >= 0; b--) begin
         // bits past the last pair of the triangle are dropped
         if (shadow_col >= shadow_size) return;
         if (val[b]) begin
            shadow_rows[shadow_row][shadow_col] = 1'b1;
            shadow_rows[shadow_col][shadow_row] = 1'b1;
         end
         shadow_row++;
         if (shadow_row == shadow_col) begin
            shadow_row = 0;
            shadow_col++;
         end
      end
   endfunction

   function automatic bit has_square();
      for (int i = 0; i < shadow_size; i++)
         for (int j = i + 1; j < shadow_size; j++)
            if ($countones(shadow_rows[i] & shadow_rows[j]) >= 2) return 1'b1;
      return 1'b0;
   endfunction

   // Exhaustive walk for a simple cycle of cyc_len vertices through root,
   // using only vertices numbered root or higher.
   function automatic bit cycle_through(int root, int cyc_len);
      int      path[64];
      int      cursor[64];
      row_type seen;
      row_type row;
      int      depth;
      int      k;
      int      u;
      bit      pushed;
      depth     = 1;
      path[0]   = root;
      cursor[0] = root;
      seen      = '0;
      seen[root] = 1'b1;
      while (depth > 0) begin
         k      = depth - 1;
         u      = path[k];
         row    = shadow_rows[u];
         pushed = 1'b0;
         if (depth == cyc_len) begin
            if (row[root]) return 1'b1;
         end else begin
            for (int w = cursor[k]; w < shadow_size; w++) begin
               if (row[w] && !seen[w]) begin
                  cursor[k]     = w + 1;
                  path[k+1]     = w;
                  cursor[k+1]   = root;
                  seen[w]       = 1'b1;
                  depth++;
                  pushed = 1'b1;
                  break;
               end
            end
         end
         if (!pushed) begin
            if (k > 0) seen[u] = 1'b0;
            depth--;
         end
      end
      return 1'b0;
   endfunction

   function automatic bit has_cycle(int cyc_len);
      if (cyc_len < 3 || cyc_len > shadow_size) return 1'b0;
      for (int s = 0; s < shadow_size; s++)
         if (cycle_through(s, cyc_len)) return 1'b1;
      return 1'b0;
   endfunction

   // Advance the shadow by one accepted beat; queue the verdict on a last beat.
   function automatic void predict_beat(logic [7:0] byte_in, logic last_in);
      verdict_beat_type v;
      if (!shadow_hdr_seen) begin
         shadow_hdr_seen = 1'b1;
         if (byte_in < CHAR_BIAS || int'(byte_in) - CHAR_BIAS > MAX_VERTICES) begin
            shadow_hdr_bad = 1'b1;
            shadow_size    = 0;
         end else begin
            shadow_size = byte_in - CHAR_BIAS;
         end
      end else if (!shadow_hdr_bad) begin
         absorb_data(byte_in);
      end
      if (!last_in) return;
      v.verdict      = VERDICT_NONE;
      v.cycle_length = '0;
      v.vertex_count = '0;
      if (shadow_hdr_bad) begin
         v.verdict = VERDICT_BAD;
      end else begin
         v.vertex_count = vtx_type'(shadow_size);
         if (has_square()) begin
            v.verdict      = VERDICT_C4;
            v.cycle_length = vtx_type'(C4_LEN);
         end else begin
            for (int len = FIRST_LONG_LEN; len <= shadow_size; len *= 2) begin
               if (has_cycle(len)) begin
                  v.verdict      = VERDICT_LONG;
                  v.cycle_length = vtx_type'(len);
                  break;
               end
            end
         end
      end
      verdict_q.push_back(v);
      clear_shadow();
   endfunction

   // ---------------------------------------------------------------------
   // Drivers
   // ---------------------------------------------------------------------
   // Send one beat; called and returns at a falling edge.
   task automatic send_beat(logic [7:0] byte_in, logic last_in);
      while (idle_on && $urandom_range(99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_char_byte <= byte_in;
      req_last      <= last_in;
      do @(posedge clock); while (!req_ready);
      predict_beat(byte_in, last_in);
      beats_sent++;
      @(negedge clock);
   endtask

   // Hold off the sender until every verdict has come back, then let it settle.
   task automatic drain();
      req_valid <= 1'b0;
      while (verdict_q.size() != 0) @(negedge clock);
      repeat (SETTLE_WAIT) @(negedge clock);
   endtask

   // Receiver back-pressure, switched off during the no-idle stretch
   always @(negedge clock) begin
      if (reset) rsp_ready <= 1'b0;
      else rsp_ready <= !idle_on || ($urandom_range(99) >= IDLE_PCT);
   end

   // ---------------------------------------------------------------------
   // Graph helpers
   // ---------------------------------------------------------------------
   function automatic void wipe_graph();
      for (int i = 0; i < ROW_BITS; i++) graph_rows[i] = '0;
   endfunction

   function automatic void link(int a, int b);
      if (a == b) return;
      graph_rows[a][b] = 1'b1;
      graph_rows[b][a] = 1'b1;
   endfunction

   function automatic void add_ring(int first, int len);
      for (int i = 0; i < len; i++) link(first + i, first + (i + 1) % len);
   endfunction

   // Send the graph of n vertices as one line. Append extra characters past
   // the triangle, and cut the line short if cut is not negative.
   task automatic send_graph(int n, int extra, int cut);
      int pairs;
      int nchars;
      int r;
      int c;
      logic [5:0] val;
      logic [7:0] b;
      pairs  = n * (n - 1) / 2;
      nchars = (pairs + BITS_PER_CHAR - 1) / BITS_PER_CHAR + extra;
      if (cut >= 0 && cut < nchars) nchars = cut;
      send_beat(8'(n + CHAR_BIAS), nchars == 0);
      r   = 0;
      c   = 1;
      for (int k = 0; k < nchars; k++) begin
         for (int bt = BITS_PER_CHAR - 1; bt >= 0; bt--) begin
            if (c < n) begin
               val[bt] = graph_rows[r][c];
               r++;
               if (r == c) begin
                  r = 0;
                  c++;
               end
            end else begin
               val[bt] = $urandom_range(1);
            end
         end
         // any byte whose biased low six bits match carries the same bits
         b = 8'(val + CHAR_BIAS + 64 * $urandom_range(3));
         send_beat(b, k == nchars - 1);
      end
   endtask

   task automatic send_bad_line(logic [7:0] hdr, int ndata);
      send_beat(hdr, ndata == 0);
      for (int k = 0; k < ndata; k++) send_beat(8'($urandom_range(255)), k == ndata - 1);
   endtask

   function automatic logic [7:0] random_bad_header();
      if ($urandom_range(1)) return 8'($urandom_range(CHAR_BIAS - 1));
      return 8'($urandom_range(255, CHAR_BIAS + MAX_VERTICES + 1));
   endfunction

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------
   task automatic test_headers();
      wipe_graph();
      send_graph(0, 0, -1);                       // header is last, empty graph
      send_graph(MAX_VERTICES, 0, 0);             // largest count, no data
      send_bad_line(8'd0, 0);
      send_bad_line(8'd255, 2);                   // data after a bad header is dropped
      send_bad_line(8'(CHAR_BIAS - 1), 0);
      send_bad_line(8'(CHAR_BIAS + MAX_VERTICES + 1), 1);
   endtask

   task automatic test_square();
      wipe_graph();
      add_ring(0, 4);
      send_graph(4, 0, -1);
   endtask

   task automatic test_ring_eight();
      wipe_graph();
      add_ring(0, 8);
      send_graph(8, 0, -1);
   endtask

   task automatic test_line_edges();
      // extra characters past the triangle, then a line cut short
      wipe_graph();
      link(0, 1);
      link(3, 4);
      send_graph(5, 2, -1);
      wipe_graph();
      add_ring(0, 8);
      send_graph(10, 0, 3);
   endtask

   task automatic test_random();
      int kind;
      int n;
      int len;
      int pct;
      while (beats_sent < RANDOM_BEATS) begin
         // a stretch with no idling on either side
         idle_on = !(beats_sent >= 120 && beats_sent < 240);
         kind = $urandom_range(99);
         wipe_graph();
         if (kind < 55) begin
            n   = $urandom_range(12, 2);
            pct = $urandom_range(60, 5);
            for (int i = 0; i < n; i++)
               for (int j = i + 1; j < n; j++)
                  if ($urandom_range(99) < pct) link(i, j);
            send_graph(n, $urandom_range(1), -1);
         end else if (kind < 72) begin
            case ($urandom_range(5))
               0, 1, 2: len = 8;
               3, 4:    len = 16;
               default: len = 32;
            endcase
            n = len + $urandom_range(len == 32 ? 2 : 5);
            add_ring($urandom_range(n - len), len);
            if ($urandom_range(2) == 0) link($urandom_range(n - 1), $urandom_range(n - 1));
            send_graph(n, 0, -1);
         end else if (kind < 76) begin
            n = $urandom_range(MAX_VERTICES, 40);
            for (int e = 0; e < 4; e++) link($urandom_range(n - 1), $urandom_range(n - 1));
            send_graph(n, 0, $urandom_range(3) == 0 ? $urandom_range(20) : -1);
         end else if (kind < 88) begin
            send_bad_line(random_bad_header(), $urandom_range(4));
         end else begin
            n = $urandom_range(14, 4);
            add_ring(0, n > 8 ? 8 : 4);
            for (int e = 0; e < 3; e++) link($urandom_range(n - 1), $urandom_range(n - 1));
            send_graph(n, $urandom_range(3), $urandom_range(3) == 0 ? $urandom_range(6) : -1);
         end
      end
      idle_on = 1'b1;
   endtask

   // ---------------------------------------------------------------------
   // Checker: compare each verdict beat with the oldest prediction
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      verdict_beat_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (verdict_q.size() == 0) begin
            $error("unexpected verdict beat: verdict %0d", rsp_verdict);
            error_count++;
         end else begin
            want = verdict_q.pop_front();
            if (rsp_verdict !== want.verdict) begin
               $error("verdict: expected %0d actual %0d", want.verdict, rsp_verdict);
               error_count++;
            end
            if (rsp_cycle_length !== want.cycle_length) begin
               $error("cycle_length: expected %0d actual %0d",
                      want.cycle_length, rsp_cycle_length);
               error_count++;
            end
            if (rsp_vertex_count !== want.vertex_count) begin
               $error("vertex_count: expected %0d actual %0d",
                      want.vertex_count, rsp_vertex_count);
               error_count++;
            end
         end
      end
   end

   // Watchdog: drop out if neither channel moves a beat for too long
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         stall_count <= 0;
      end else begin
         stall_count <= stall_count + 1;
         if (stall_count >= STALL_LIMIT) begin
            $display("TB_ERROR");
            $finish;
         end
      end
   end

   initial begin
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_char_byte = '0;
      req_last      = 1'b0;
      clear_shadow();
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_headers();
      test_square();
      test_ring_eight();
      drain();
      test_line_edges();
      drain();
      test_random();
      drain();
      if (error_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
